### hw/rtl/dt2e_pkg.sv
// ============================================================================
// dt2e_pkg
// Shared types, constants and helper functions for the date-time text to
// epoch seconds converter.
// ============================================================================
package dt2e_pkg;

    // Number of register stages from input acceptance to the output register.
    localparam int STAGES = 6;

    // Calendar and scaling constants.
    localparam logic [31:0] EPOCH_DAYS    = 32'd719163;
    localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
    localparam logic [31:0] SECS_PER_MIN  = 32'd60;
    localparam logic [31:0] DAYS_PER_YEAR = 32'd365;

    // Weighted ASCII code of '0' for two and four digit groups.
    localparam logic [12:0] ZERO_X11   = 13'd528;
    localparam logic [31:0] ZERO_X1111 = 32'd53328;

    // Reciprocal of 100 scaled by 2^37; exact quotient for any 32-bit dividend.
    localparam logic [30:0] RECIP_100  = 31'd1374389535;
    localparam int          RECIP_SHIFT = 37;

    // One enable or valid bit per pipeline stage.
    typedef logic [STAGES-1:0] stage_vec_t;

    // Decoded fields leaving the first stage. Small fields are 13-bit two's
    // complement values; their 32-bit wrapped value is the sign extension.
    typedef struct packed {
        logic [31:0] ym1;
        logic [3:0]  month_idx;
        logic        month_ok;
        logic        month_gt2;
        logic [12:0] day;
        logic [12:0] hour;
        logic [12:0] minute;
        logic [12:0] second;
    } parse_t;

    // Two ASCII digits to a wrapped value, tens digit in the upper byte.
    function automatic logic [12:0] two_digits(input logic [15:0] text);
        logic [11:0] sum;
        sum = 12'(text[15:8]) * 12'd10 + 12'(text[7:0]);
        return {1'b0, sum} - ZERO_X11;
    endfunction

    // Sign extension of a 13-bit value to the 32-bit wrapped value.
    function automatic logic [31:0] sext13(input logic [12:0] v);
        return {{19{v[12]}}, v};
    endfunction

    // Days in the year before the first of the month, by month index 0..11.
    function automatic logic [8:0] cum_days(input logic [3:0] idx);
        logic [8:0] d;
        case (idx)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

### hw/rtl/dt2e_parse.sv
// ============================================================================
// dt2e_parse
// First pipeline stage: converts the ASCII digit groups to binary values.
// ============================================================================
module dt2e_parse (
    input  logic              clk,
    input  logic              en,
    input  logic [31:0]       year_text,
    input  logic [15:0]       month_text,
    input  logic [15:0]       day_text,
    input  logic [15:0]       hour_text,
    input  logic [15:0]       minute_text,
    input  logic [15:0]       second_text,
    output dt2e_pkg::parse_t  fields
);
    import dt2e_pkg::*;

    logic [18:0] year_sum;
    logic [12:0] month_val;
    parse_t      fields_next;
    parse_t      fields_reg;

    // Weighted sum of the four year digit codes; it never exceeds 19 bits.
    assign year_sum = 19'(year_text[31:24]) * 19'd1000
                    + 19'(year_text[23:16]) * 19'd100
                    + 19'(year_text[15:8])  * 19'd10
                    + 19'(year_text[7:0]);

    assign month_val = two_digits(month_text);

    // The year minus one is what the day count needs; the leap test uses it too.
    always_comb
    begin
        fields_next.ym1       = {13'd0, year_sum} - ZERO_X1111 - 32'd1;
        fields_next.month_idx = month_val[3:0] - 4'd1;
        fields_next.month_ok  = ($signed(month_val) >= 13'sd1)
                             && ($signed(month_val) <= 13'sd12);
        // A negative value wraps to a large unsigned month, which is above two.
        fields_next.month_gt2 = month_val[12] || ($signed(month_val) > 13'sd2);
        fields_next.day       = two_digits(day_text);
        fields_next.hour      = two_digits(hour_text);
        fields_next.minute    = two_digits(minute_text);
        fields_next.second    = two_digits(second_text);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fields_reg <= fields_next;
        end
    end

    assign fields = fields_reg;

endmodule

### hw/rtl/dt2e_daycount.sv
// ============================================================================
// dt2e_daycount
// Stages two to four: leap corrections, day count since the epoch and the
// time of day in seconds.
// ============================================================================
module dt2e_daycount (
    input  logic              clk,
    input  logic [2:0]        en,
    input  dt2e_pkg::parse_t  fields,
    output logic [31:0]       days,
    output logic [31:0]       tod
);
    import dt2e_pkg::*;

    // Stage two registers.
    logic [62:0] recip_prod;
    logic [25:0] q100_next;
    logic [31:0] dayp_next;
    logic [31:0] tod_next;
    logic [31:0] s2_ym1_reg;
    logic [25:0] s2_q100_reg;
    logic        s2_gt2_reg;
    logic [31:0] s2_dayp_reg;
    logic [31:0] s2_tod_reg;

    // Stage three registers.
    logic [23:0] q400;
    logic [6:0]  r100;
    logic [8:0]  r400;
    logic        leap_next;
    logic [31:0] base_next;
    logic [31:0] s3_base_reg;
    logic        s3_leap_reg;
    logic [31:0] s3_dayp_reg;
    logic [31:0] s3_tod_reg;

    // Stage four registers.
    logic [31:0] days_next;
    logic [31:0] days_reg;
    logic [31:0] tod_reg;

    // Quotient by 100 through the scaled reciprocal.
    assign recip_prod = 63'(fields.ym1) * 63'(RECIP_100);
    assign q100_next  = recip_prod[62:RECIP_SHIFT];

    // Day of year before the leap day, and the time of day.
    assign dayp_next = sext13(fields.day)
                     + (fields.month_ok ? 32'(cum_days(fields.month_idx)) : 32'd0);
    assign tod_next  = sext13(fields.hour) * SECS_PER_HOUR
                     + sext13(fields.minute) * SECS_PER_MIN
                     + sext13(fields.second);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s2_ym1_reg  <= fields.ym1;
            s2_q100_reg <= q100_next;
            s2_gt2_reg  <= fields.month_gt2;
            s2_dayp_reg <= dayp_next;
            s2_tod_reg  <= tod_next;
        end
    end

    // The year is the year minus one plus one, so a leap year shows as a
    // remainder of three, ninety-nine or three hundred ninety-nine.
    assign q400 = s2_q100_reg[25:2];
    assign r100 = s2_ym1_reg[6:0] - 7'(s2_q100_reg[6:0] * 7'd100);
    assign r400 = s2_ym1_reg[8:0] - 9'(q400[8:0] * 9'd400);
    assign leap_next = (r400 == 9'd399)
                    || ((s2_ym1_reg[1:0] == 2'b11) && (r100 != 7'd99));

    // Days in all whole years before this one.
    assign base_next = s2_ym1_reg * DAYS_PER_YEAR
                     + {2'b00, s2_ym1_reg[31:2]}
                     - {6'd0, s2_q100_reg}
                     + {8'd0, q400};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s3_base_reg <= base_next;
            s3_leap_reg <= leap_next && s2_gt2_reg;
            s3_dayp_reg <= s2_dayp_reg;
            s3_tod_reg  <= s2_tod_reg;
        end
    end

    // Day count relative to the epoch.
    assign days_next = s3_dayp_reg + s3_base_reg + {31'd0, s3_leap_reg} - EPOCH_DAYS;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            days_reg <= days_next;
            tod_reg  <= s3_tod_reg;
        end
    end

    assign days = days_reg;
    assign tod  = tod_reg;

endmodule

### hw/rtl/dt2e_scale.sv
// ============================================================================
// dt2e_scale
// Stages five and six: scales the day count to seconds and adds the time of
// day into the output register.
// ============================================================================
module dt2e_scale (
    input  logic               clk,
    input  logic [1:0]         en,
    input  logic [31:0]        days,
    input  logic [31:0]        tod,
    output logic signed [31:0] epoch_seconds
);
    import dt2e_pkg::*;

    logic [31:0] prod_next;
    logic [31:0] prod_reg;
    logic [31:0] tod_reg;
    logic [31:0] secs_next;
    logic [31:0] secs_reg;

    // Day count times seconds per day, modulo 2^32.
    assign prod_next = days * SECS_PER_DAY;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            prod_reg <= prod_next;
            tod_reg  <= tod;
        end
    end

    // Final sum into the output register.
    assign secs_next = prod_reg + tod_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            secs_reg <= secs_next;
        end
    end

    assign epoch_seconds = $signed(secs_reg);

endmodule

### hw/rtl/datetime_text_to_epoch_seconds.sv
// Throughput: one transaction per cycle while out_stall is low. Each accepted
// transaction passes the six stages to out_valid; each stage holds one item
// and moves on whenever the stage after it is empty or moving.
// The widest step is the 32 by 31 bit reciprocal multiply in stage two.
// Reset clears the stage valid bits only; data registers are not reset.
// ============================================================================
// datetime_text_to_epoch_seconds
// Converts ASCII digits of a date-time YYYYMMDDHHMMSS to Unix epoch seconds.
// ============================================================================
module datetime_text_to_epoch_seconds (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        year_text,
    input  logic [15:0]        month_text,
    input  logic [15:0]        day_text,
    input  logic [15:0]        hour_text,
    input  logic [15:0]        minute_text,
    input  logic [15:0]        second_text,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] epoch_seconds
);
    import dt2e_pkg::*;

    stage_vec_t  valid_reg;
    stage_vec_t  valid_next;
    stage_vec_t  stage_en;
    parse_t      fields;
    logic [31:0] days;
    logic [31:0] tod;

    // A stage loads when it is empty or when its item moves on.
    always_comb
    begin
        stage_en[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    // Valid bits follow their data through the stages.
    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !stage_en[0];
    assign out_valid = valid_reg[STAGES-1];

    // Digit decoding.
    dt2e_parse u_parse (
        .clk         (clk),
        .en          (stage_en[0]),
        .year_text   (year_text),
        .month_text  (month_text),
        .day_text    (day_text),
        .hour_text   (hour_text),
        .minute_text (minute_text),
        .second_text (second_text),
        .fields      (fields)
    );

    // Leap corrections and day count.
    dt2e_daycount u_daycount (
        .clk    (clk),
        .en     (stage_en[3:1]),
        .fields (fields),
        .days   (days),
        .tod    (tod)
    );

    // Scaling to seconds.
    dt2e_scale u_scale (
        .clk           (clk),
        .en            (stage_en[5:4]),
        .days          (days),
        .tod           (tod),
        .epoch_seconds (epoch_seconds)
    );

    // The input only stalls when every stage is full and the output is held.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ((&valid_reg) && out_stall))
    else $error("input stalled while the pipeline had room");

    // The item count changes only by accepted input and output transactions.
    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) == $past($countones(valid_reg))
                  + ($past(in_valid && !in_stall) ? 1 : 0)
                  - ($past(out_valid && !out_stall) ? 1 : 0)))
    else $error("pipeline lost or invented an item");

    // A held output keeps its valid bit in the next cycle.
    a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[STAGES-1] && out_stall) |=> valid_reg[STAGES-1])
    else $error("stalled result dropped from the output stage");

endmodule

### verif/epoch_seconds_checker.sv
// ============================================================================
// epoch_seconds_checker
// Watches both channels of the date-time text to epoch seconds converter,
// predicts the seconds count of every accepted input transaction and
// compares each accepted result, in order, against that prediction.
// ============================================================================
module epoch_seconds_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [31:0]        year_text,
    input  logic [15:0]        month_text,
    input  logic [15:0]        day_text,
    input  logic [15:0]        hour_text,
    input  logic [15:0]        minute_text,
    input  logic [15:0]        second_text,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] epoch_seconds,
    output int                 mismatch_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import dt2e_pkg::*;

    // Days in the year before the first of each month, January first.
    logic [31:0] days_before_month [12];

    // Predicted seconds counts, oldest transaction first.
    logic [31:0] expected_epochs [$];
    logic [31:0] oldest_epoch;
    int          failures;

    initial
    begin
        days_before_month = '{32'd0, 32'd31, 32'd59, 32'd90, 32'd120, 32'd151,
                              32'd181, 32'd212, 32'd243, 32'd273, 32'd304, 32'd334};
    end

    // Converts two ASCII characters to a wrapped value, no digit check.
    function automatic logic [31:0] pair_value(input logic [15:0] chars);
        return 32'(chars[15:8]) * 32'd10 + 32'(chars[7:0]) - 32'(ZERO_X11);
    endfunction

    // Gregorian leap year test on the wrapped year value.
    function automatic logic leap_year(input logic [31:0] year);
        return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
    endfunction

    // Seconds since the Unix epoch for one date-time, all sums modulo 2^32.
    function automatic logic [31:0] predict_epoch(
        input logic [31:0] year_chars,
        input logic [15:0] month_chars,
        input logic [15:0] day_chars,
        input logic [15:0] hour_chars,
        input logic [15:0] minute_chars,
        input logic [15:0] second_chars
    );
        logic [31:0] year;
        logic [31:0] month;
        logic [31:0] days;
        logic [31:0] prior_years;
        year = 32'(year_chars[31:24]) * 32'd1000 + 32'(year_chars[23:16]) * 32'd100
             + 32'(year_chars[15:8]) * 32'd10 + 32'(year_chars[7:0]) - ZERO_X1111;
        month = pair_value(month_chars);
        days  = pair_value(day_chars);

        // Month table offset only for real months; leap day for any month past February.
        if (month >= 32'd1 && month <= 32'd12)
            days = days + days_before_month[month - 32'd1];
        if (month > 32'd2 && leap_year(year))
            days = days + 32'd1;

        // Whole years before this one, with the 4/100/400 corrections.
        prior_years = year - 32'd1;
        days = days + DAYS_PER_YEAR * prior_years + prior_years / 4
             - prior_years / 100 + prior_years / 400;

        return (days - EPOCH_DAYS) * SECS_PER_DAY
             + pair_value(hour_chars) * SECS_PER_HOUR
             + pair_value(minute_chars) * SECS_PER_MIN
             + pair_value(second_chars);
    endfunction

    // Compare results first, then record new input transactions, so that a
    // result never matches an input accepted on the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_epochs.delete();
            failures       = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_epochs.size() == 0)
                begin
                    failures++;
                    $error("epoch_seconds: expected no transaction, actual %0d",
                           epoch_seconds);
                end
                else
                begin
                    oldest_epoch = expected_epochs.pop_front();
                    if (oldest_epoch !== epoch_seconds)
                    begin
                        failures++;
                        $error("epoch_seconds: expected %0d, actual %0d",
                               $signed(oldest_epoch), epoch_seconds);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                expected_epochs.push_back(predict_epoch(year_text, month_text, day_text,
                                                        hour_text, minute_text,
                                                        second_text));
            end
            mismatch_count <= failures;
            pending_count  <= expected_epochs.size();
        end
    end

endmodule

### verif/datetime_text_to_epoch_seconds_test.sv
// ============================================================================
// datetime_text_to_epoch_seconds_test
// Drives date-time text into the converter: calendar edge cases first, then
// random well-formed dates mixed with out-of-range digits and raw bytes,
// under bursty input traffic and a varying output stall pattern.
// ============================================================================
module datetime_text_to_epoch_seconds_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dt2e_pkg::*;

    localparam int RANDOM_ITEMS    = 1600;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_START  = 300;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int DRAIN_CYCLES    = 2 * STAGES + 4;

    typedef struct packed {
        logic [31:0] year;
        logic [15:0] month;
        logic [15:0] day;
        logic [15:0] hour;
        logic [15:0] minute;
        logic [15:0] second;
    } dt_text_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [31:0]        year_text = '0;
    logic [15:0]        month_text = '0;
    logic [15:0]        day_text = '0;
    logic [15:0]        hour_text = '0;
    logic [15:0]        minute_text = '0;
    logic [15:0]        second_text = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] epoch_seconds;

    int mismatch_count;
    int pending_count;
    int burst_left = 0;
    int quiet_cycles = 0;

    datetime_text_to_epoch_seconds dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .year_text     (year_text),
        .month_text    (month_text),
        .day_text      (day_text),
        .hour_text     (hour_text),
        .minute_text   (minute_text),
        .second_text   (second_text),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .epoch_seconds (epoch_seconds)
    );

    epoch_seconds_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .year_text      (year_text),
        .month_text     (month_text),
        .day_text       (day_text),
        .hour_text      (hour_text),
        .minute_text    (minute_text),
        .second_text    (second_text),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .epoch_seconds  (epoch_seconds),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // 8 ns clock.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Two ASCII digits of a value 0..99.
    function automatic logic [15:0] pair_text(input int unsigned value);
        return {8'(8'h30 + value / 10), 8'(8'h30 + value % 10)};
    endfunction

    // Text of one date-time from its numeric parts.
    function automatic dt_text_t date_text(input int unsigned year, input int unsigned month,
                                           input int unsigned day, input int unsigned hour,
                                           input int unsigned minute,
                                           input int unsigned second);
        dt_text_t t;
        t.year   = {8'(8'h30 + year / 1000), 8'(8'h30 + (year / 100) % 10),
                    8'(8'h30 + (year / 10) % 10), 8'(8'h30 + year % 10)};
        t.month  = pair_text(month);
        t.day    = pair_text(day);
        t.hour   = pair_text(hour);
        t.minute = pair_text(minute);
        t.second = pair_text(second);
        return t;
    endfunction

    // Offers one transaction and returns at the edge that accepts it. A new
    // burst may open with a gap; within a burst valid stays high.
    task automatic offer(input dt_text_t t);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        year_text   <= t.year;
        month_text  <= t.month;
        day_text    <= t.day;
        hour_text   <= t.hour;
        minute_text <= t.minute;
        second_text <= t.second;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        dt_text_t    noise;
        int unsigned pick;
        int unsigned year;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Epoch, both ends of the signed 32-bit range and the wrap past them.
        offer(date_text(1970, 1, 1, 0, 0, 0));
        offer(date_text(1969, 12, 31, 23, 59, 59));
        offer(date_text(2038, 1, 19, 3, 14, 7));
        offer(date_text(2038, 1, 19, 3, 14, 8));
        offer(date_text(1901, 12, 13, 20, 45, 52));
        offer(date_text(1901, 12, 13, 20, 45, 51));
        // Year zero, where the year before wraps, and the largest year.
        offer(date_text(0, 1, 1, 0, 0, 0));
        offer(date_text(0, 3, 1, 0, 0, 0));
        offer(date_text(9999, 12, 31, 23, 59, 59));
        // Leap rules: by 400, by 100, by 4, and a common year.
        offer(date_text(2000, 2, 29, 12, 0, 0));
        offer(date_text(2000, 3, 1, 0, 0, 0));
        offer(date_text(1900, 3, 1, 0, 0, 0));
        offer(date_text(2100, 3, 1, 0, 0, 0));
        offer(date_text(2024, 3, 1, 0, 0, 0));
        offer(date_text(2023, 3, 1, 0, 0, 0));
        offer(date_text(2001, 2, 28, 23, 59, 59));
        // Months outside one to twelve, fields at 99, and a day of zero.
        offer(date_text(2020, 0, 15, 6, 30, 0));
        offer(date_text(2020, 13, 1, 0, 0, 0));
        offer(date_text(1999, 99, 99, 99, 99, 99));
        offer(date_text(2012, 2, 0, 0, 0, 0));
        // Bytes that are not digits: all clear, all set, and mixed text.
        offer(dt_text_t'{32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0});
        offer(dt_text_t'{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        offer(dt_text_t'{"2O2X", "1-", " 9", "::", "Zz", 16'h7F30});

        // Mostly valid date-times, some with any two digits, some raw bytes.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                year = $urandom_range(0, 1) ? $urandom_range(1901, 2038)
                                            : $urandom_range(0, 9999);
                offer(date_text(year, $urandom_range(1, 12), $urandom_range(1, 31),
                                $urandom_range(0, 23), $urandom_range(0, 59),
                                $urandom_range(0, 59)));
            end
            else if (pick < 85)
            begin
                offer(date_text($urandom_range(0, 9999), $urandom_range(0, 99),
                                $urandom_range(0, 99), $urandom_range(0, 99),
                                $urandom_range(0, 99), $urandom_range(0, 99)));
            end
            else
            begin
                noise.year   = $urandom();
                noise.month  = 16'($urandom());
                noise.day    = 16'($urandom());
                noise.hour   = 16'($urandom());
                noise.minute = 16'($urandom());
                noise.second = 16'($urandom());
                offer(noise);
            end
        end
        in_valid <= 1'b0;

        // Let the pipeline drain, then watch for stray results.
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Output stall pattern in segments of random mode and length, with one
    // long hold-off early in the random traffic so that the pipeline fills.
    initial
    begin
        stall_mode_t mode;
        int          length;
        int          elapsed;
        elapsed = 0;
        @(posedge rst_n);
        forever
        begin
            mode   = stall_mode_t'($urandom_range(0, 2));
            length = $urandom_range(20, 200);
            repeat (length)
            begin
                case (mode)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= 1'b0;
                endcase
                @(posedge clk);
                elapsed++;
                if (elapsed == HOLD_OFF_START)
                begin
                    out_stall <= 1'b1;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
            end
        end
    end

    // Ends the run when neither channel has moved for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

### sim.f
hw/rtl/dt2e_pkg.sv
hw/rtl/dt2e_parse.sv
hw/rtl/dt2e_daycount.sv
hw/rtl/dt2e_scale.sv
hw/rtl/datetime_text_to_epoch_seconds.sv
verif/epoch_seconds_checker.sv
verif/datetime_text_to_epoch_seconds_test.sv
